// File: design/gsfp_pkg.sv
// Shared types for the gimbal status frame parser.
`timescale 1ns / 1ps

package gsfp_pkg;

  // Number of stored payload bytes (frame offsets 8 through 19).
  localparam int unsigned PayloadDepth = 12;
  localparam int unsigned PayloadIdxW  = $clog2(PayloadDepth);

  // One decoded result item as it travels from the parser to the output stage.
  typedef struct packed {
    logic               frame_kind;
    logic signed [15:0] yaw_tenths;
    logic signed [15:0] pitch_tenths;
    logic signed [15:0] roll_tenths;
    logic signed [15:0] yaw_rate_tenths;
    logic signed [15:0] pitch_rate_tenths;
    logic signed [15:0] roll_rate_tenths;
    logic [7:0]         zoom_whole;
    logic [7:0]         zoom_tenth;
  } res_t;

endpackage

// File: design/gsfp_frame_fsm.sv
// Byte-serial frame tracker: header hunt, command decode and payload capture.
`timescale 1ns / 1ps

module gsfp_frame_fsm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_take_i,
  input  logic [7:0]    rx_byte_i,
  output logic          res_push_o,
  output gsfp_pkg::res_t res_o
);
  import gsfp_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_COLLECT,
    PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_POSE,
    CLS_ZOOM
  } class_e;

  localparam logic [7:0] HdrFirst  = 8'h55;
  localparam logic [7:0] HdrSecond = 8'h66;
  localparam logic [7:0] CmdPose   = 8'h0d;
  localparam logic [7:0] CmdZoom   = 8'h18;

  localparam logic [4:0] PosStart  = 5'd2;
  localparam logic [4:0] PosCmd    = 5'd7;
  localparam logic [4:0] PosData   = 5'd8;
  localparam logic [4:0] PosDataEnd = 5'd20;  // one past the last stored offset
  localparam logic [4:0] PosPoseLast = 5'd21;
  localparam logic [4:0] PosZoomLast = 5'd11;
  localparam logic [4:0] PosSkipLast = 5'd9;

  phase_e phase_q, phase_d;
  logic [4:0] pos_q, pos_d;
  class_e cls_q, cls_d;
  class_e cls_now;
  logic skip_now;

  logic [7:0] payload_q [PayloadDepth];
  logic                   wr_en;
  logic [PayloadIdxW-1:0] wr_idx;

  assign wr_idx = PayloadIdxW'(pos_q - PosData);

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    cls_d      = cls_q;
    cls_now    = cls_q;
    skip_now   = 1'b0;
    res_push_o = 1'b0;
    wr_en      = 1'b0;
    if (byte_take_i) begin
      unique case (phase_q)
        PH_HUNT1: begin
          if (rx_byte_i == HdrFirst) begin
            phase_d = PH_HUNT2;
          end
        end
        PH_HUNT2: begin
          if (rx_byte_i == HdrSecond) begin
            phase_d = PH_COLLECT;
            pos_d   = PosStart;
            cls_d   = CLS_NONE;
          end else if (rx_byte_i != HdrFirst) begin
            phase_d = PH_HUNT1;
          end
        end
        PH_SKIP: begin
          if (pos_q >= PosSkipLast) begin
            phase_d = PH_HUNT1;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 5'd1;
          end
        end
        PH_COLLECT: begin
          if (pos_q == PosCmd) begin
            if (rx_byte_i == CmdPose) begin
              cls_now = CLS_POSE;
            end else if (rx_byte_i == CmdZoom) begin
              cls_now = CLS_ZOOM;
            end else begin
              skip_now = 1'b1;
              phase_d  = PH_SKIP;
              pos_d    = PosData;
            end
          end else if (pos_q >= PosData && pos_q < PosDataEnd) begin
            wr_en = 1'b1;
          end
          if (!skip_now) begin
            if ((cls_now == CLS_POSE && pos_q >= PosPoseLast) ||
                (cls_now == CLS_ZOOM && pos_q >= PosZoomLast)) begin
              res_push_o = 1'b1;
              phase_d    = PH_HUNT1;
              pos_d      = '0;
              cls_d      = CLS_NONE;
            end else if (pos_q >= PosPoseLast) begin
              phase_d = PH_HUNT1;
              pos_d   = '0;
              cls_d   = CLS_NONE;
            end else begin
              pos_d = pos_q + 5'd1;
              cls_d = cls_now;
            end
          end
        end
        default: begin
          phase_d = PH_HUNT1;
        end
      endcase
    end
  end

  // The last byte of a frame is never one of the bytes it reports, so the
  // result is built from the stored payload alone.
  always_comb begin
    res_o = '0;
    if (cls_now == CLS_ZOOM) begin
      res_o.frame_kind = 1'b1;
      res_o.zoom_whole = payload_q[0];
      res_o.zoom_tenth = payload_q[1];
    end else begin
      res_o.frame_kind        = 1'b0;
      res_o.yaw_tenths        = {payload_q[1], payload_q[0]};
      res_o.pitch_tenths      = {payload_q[3], payload_q[2]};
      res_o.roll_tenths       = {payload_q[5], payload_q[4]};
      res_o.yaw_rate_tenths   = {payload_q[7], payload_q[6]};
      res_o.pitch_rate_tenths = {payload_q[9], payload_q[8]};
      res_o.roll_rate_tenths  = {payload_q[11], payload_q[10]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      pos_q   <= '0;
      cls_q   <= CLS_NONE;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cls_q   <= cls_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      payload_q[wr_idx] <= rx_byte_i;
    end
  end

endmodule

// File: design/gsfp_out_stage.sv
// Result output register with a one-entry skid register behind it.
`timescale 1ns / 1ps

module gsfp_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gsfp_pkg::res_t res_i,
  output logic           full_o,
  output logic           res_valid_o,
  input  logic           res_stall_i,
  output gsfp_pkg::res_t res_o
);
  import gsfp_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop = out_valid_q && !res_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // The upstream side is held off while the skid entry is occupied.
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// File: design/gimbal_status_frame_parser.sv
// Top level of the gimbal status frame parser.
`timescale 1ns / 1ps

// The block takes a received byte stream on the rx channel (rx_valid_i,
// rx_stall_o, rx_byte_i) and gives decoded frames on the res channel
// (res_valid_o, res_stall_i and one port per result field).
// An item on either channel moves at a rising edge where valid is high and
// stall is low.
// The parser hunts for the header bytes 0x55 then 0x66, reads the command at
// frame offset 7, and emits one result item after the last byte of a 22-byte
// pose frame or a 12-byte zoom frame. Frames with any other command have
// their first ten bytes dropped before the hunt starts again.
// One byte is accepted every cycle unless rx_stall_o is high. A result item
// is registered at the edge that accepts the last byte of its frame. Unused
// fields of a result item are zero.
// When the receiver stalls, a finished result waits in the output register
// and one more result can wait in a skid register behind it, so bytes keep
// flowing. Only when both are full is rx_stall_o raised.
// Reset clears the hunt state and empties the output and skid registers.
// The stored payload bytes are not cleared; every byte a result reports is
// written earlier in the same frame.

module gimbal_status_frame_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  output logic               rx_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic               frame_kind_o,
  output logic signed [15:0] yaw_tenths_o,
  output logic signed [15:0] pitch_tenths_o,
  output logic signed [15:0] roll_tenths_o,
  output logic signed [15:0] yaw_rate_tenths_o,
  output logic signed [15:0] pitch_rate_tenths_o,
  output logic signed [15:0] roll_rate_tenths_o,
  output logic [7:0]         zoom_whole_o,
  output logic [7:0]         zoom_tenth_o
);
  import gsfp_pkg::*;

  logic byte_take;
  logic res_push;
  logic stage_full;
  res_t res_new;
  res_t res_out;

  // A byte is taken whenever the output side has room for one more result.
  assign rx_stall_o = stage_full;
  assign byte_take  = rx_valid_i && !stage_full;

  gsfp_frame_fsm u_frame_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_take_i (byte_take),
    .rx_byte_i   (rx_byte_i),
    .res_push_o  (res_push),
    .res_o       (res_new)
  );

  gsfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .res_i       (res_new),
    .full_o      (stage_full),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_o       (res_out)
  );

  assign frame_kind_o        = res_out.frame_kind;
  assign yaw_tenths_o        = res_out.yaw_tenths;
  assign pitch_tenths_o      = res_out.pitch_tenths;
  assign roll_tenths_o       = res_out.roll_tenths;
  assign yaw_rate_tenths_o   = res_out.yaw_rate_tenths;
  assign pitch_rate_tenths_o = res_out.pitch_rate_tenths;
  assign roll_rate_tenths_o  = res_out.roll_rate_tenths;
  assign zoom_whole_o        = res_out.zoom_whole;
  assign zoom_tenth_o        = res_out.zoom_tenth;

endmodule
